@@ src/cls_pkg.sv @@
package cls_pkg;

	localparam int TIME_W    = 32;
	localparam int CONFIRM_W = 16;
	localparam int COUNT_W   = 8;

	localparam logic [COUNT_W-1:0] COUNT_MAX = 8'd255;

	// reset values of the configuration registers (Q1.10 confidences)
	localparam int RST_ENTER   = 717;
	localparam int RST_EXIT    = 512;
	localparam int RST_HARD    = 922;
	localparam int RST_MARGIN  = 102;
	localparam int RST_CONFIRM = 1000;
	localparam int RST_RELEASE = 3;

	typedef enum logic [2:0] {
		CFG_ENTER   = 3'd0,
		CFG_EXIT    = 3'd1,
		CFG_HARD    = 3'd2,
		CFG_MARGIN  = 3'd3,
		CFG_CONFIRM = 3'd4,
		CFG_RELEASE = 3'd5
	} cfg_idx_t;

	typedef enum logic {
		ACT_CLASSIFY = 1'b0,
		ACT_CLEAR    = 1'b1
	} action_t;

	// control from the pipeline to the state update
	typedef struct packed {
		logic fire;
		logic clear;
		logic ready;
	} upd_ctl_t;

endpackage

@@ src/class_label_stabilizer.sv @@
// channel  | dir | handshake              | payload
// s_axis   | in  | s_axis_tvalid/tready   | tuser: action; tdata: frame fields
// m_axis   | out | m_axis_tvalid/tready   | tdata: stable and live labels
// cfg      | in  | cfg_we                 | cfg_index, cfg_data, no read-back
//
// One item per cycle while m_axis_tready is high. Input register, then the
// compare-and-update logic writes the state and the result register together.
// The input register keeps taking items while a result waits, until both stages
// are full; m_axis_tready low stalls both stages.
// arst_n clears the label state and restores the register defaults.
module class_label_stabilizer #(
	parameter int CLASS_BITS = 6,
	parameter int CONF_BITS = 10
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// model_ready, class_index, is_sign_class, confidence, time_ms
	input  logic [((CLASS_BITS+CONF_BITS+35)+7)/8*8-1:0] s_axis_tdata,
	// action
	input  logic                  s_axis_tuser,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// stable_valid, stable_class, stable_confidence, live_valid, live_class
	output logic [((2*CLASS_BITS+CONF_BITS+3)+7)/8*8-1:0] m_axis_tdata,
	input  logic                  cfg_we,
	input  logic [2:0]            cfg_index,
	input  logic [((CONF_BITS+1 > 16) ? CONF_BITS+1 : 16)-1:0] cfg_data
);

	localparam int CW    = CONF_BITS + 1;
	localparam int TW    = cls_pkg::TIME_W;
	localparam int CFG_W = (CW > 16) ? CW : 16;
	localparam int OUT_R = 2 * CLASS_BITS + CONF_BITS + 3;
	localparam int OUT_W = (OUT_R + 7) / 8 * 8;
	localparam int O_CLS  = 1;
	localparam int O_SIGN = O_CLS + CLASS_BITS;
	localparam int O_CONF = O_SIGN + 1;
	localparam int O_TIME = O_CONF + CW;

	logic                     s1_valid;
	logic                     action_s1, ready_s1, sign_s1;
	logic [CLASS_BITS-1:0]    class_s1;
	logic [CW-1:0]            conf_s1;
	logic [TW-1:0]            time_s1;

	logic                     out_valid_q;
	logic [OUT_R-1:0]         out_data_q;

	logic                     out_adv, fire;
	cls_pkg::upd_ctl_t        ctl;

	logic [CW-1:0]                    enter_th, exit_th, hard_th, margin;
	logic [cls_pkg::CONFIRM_W-1:0]    confirm_ms;
	logic [cls_pkg::COUNT_W-1:0]      release_frames;

	logic                     st_valid, lv_valid;
	logic [CLASS_BITS-1:0]    st_class, lv_class;
	logic [CW-1:0]            st_conf;

	assign out_adv       = !out_valid_q || m_axis_tready;
	assign fire          = s1_valid && out_adv;
	assign s_axis_tready = !s1_valid || out_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (s_axis_tready) begin
			s1_valid <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			action_s1 <= s_axis_tuser;
			ready_s1  <= s_axis_tdata[0];
			class_s1  <= s_axis_tdata[O_CLS +: CLASS_BITS];
			sign_s1   <= s_axis_tdata[O_SIGN];
			conf_s1   <= s_axis_tdata[O_CONF +: CW];
			time_s1   <= s_axis_tdata[O_TIME +: TW];
		end
	end

	assign ctl.fire  = fire;
	assign ctl.clear = (action_s1 == cls_pkg::ACT_CLEAR);
	assign ctl.ready = ready_s1;

	cls_cfg #(
		.CONF_BITS (CONF_BITS),
		.CFG_W     (CFG_W)
	) u_cfg (
		.clk                      (clk),
		.arst_n                   (arst_n),
		.cfg_we                   (cfg_we),
		.cfg_index                (cfg_index),
		.cfg_data                 (cfg_data),
		.enter_threshold          (enter_th),
		.exit_threshold           (exit_th),
		.hard_switch_threshold    (hard_th),
		.switch_margin            (margin),
		.confirm_time_ms          (confirm_ms),
		.uncertain_release_frames (release_frames)
	);

	cls_update #(
		.CLASS_BITS (CLASS_BITS),
		.CONF_BITS  (CONF_BITS)
	) u_update (
		.clk                      (clk),
		.arst_n                   (arst_n),
		.ctl                      (ctl),
		.class_index              (class_s1),
		.is_sign_class            (sign_s1),
		.confidence               (conf_s1),
		.time_ms                  (time_s1),
		.enter_threshold          (enter_th),
		.exit_threshold           (exit_th),
		.hard_switch_threshold    (hard_th),
		.switch_margin            (margin),
		.confirm_time_ms          (confirm_ms),
		.uncertain_release_frames (release_frames),
		.stable_valid             (st_valid),
		.stable_class             (st_class),
		.stable_confidence        (st_conf),
		.live_valid               (lv_valid),
		.live_class               (lv_class)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_adv) begin
			out_valid_q <= s1_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (fire)
			out_data_q <= {lv_class, lv_valid, st_conf, st_class, st_valid};
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = OUT_W'(out_data_q);

endmodule

@@ src/cls_cfg.sv @@
module cls_cfg #(
	parameter int CONF_BITS = 10,
	parameter int CFG_W = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [2:0]                      cfg_index,
	input  logic [CFG_W-1:0]                cfg_data,
	output logic [CONF_BITS:0]              enter_threshold,
	output logic [CONF_BITS:0]              exit_threshold,
	output logic [CONF_BITS:0]              hard_switch_threshold,
	output logic [CONF_BITS:0]              switch_margin,
	output logic [cls_pkg::CONFIRM_W-1:0]   confirm_time_ms,
	output logic [cls_pkg::COUNT_W-1:0]     uncertain_release_frames
);

	localparam int CW = CONF_BITS + 1;

	logic [CW-1:0]                    enter_q, exit_q, hard_q, margin_q;
	logic [cls_pkg::CONFIRM_W-1:0]    confirm_q;
	logic [cls_pkg::COUNT_W-1:0]      release_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enter_q   <= CW'(cls_pkg::RST_ENTER);
			exit_q    <= CW'(cls_pkg::RST_EXIT);
			hard_q    <= CW'(cls_pkg::RST_HARD);
			margin_q  <= CW'(cls_pkg::RST_MARGIN);
			confirm_q <= cls_pkg::CONFIRM_W'(cls_pkg::RST_CONFIRM);
			release_q <= cls_pkg::COUNT_W'(cls_pkg::RST_RELEASE);
		end else if (cfg_we) begin
			unique case (cfg_index)
				cls_pkg::CFG_ENTER:   enter_q   <= cfg_data[CW-1:0];
				cls_pkg::CFG_EXIT:    exit_q    <= cfg_data[CW-1:0];
				cls_pkg::CFG_HARD:    hard_q    <= cfg_data[CW-1:0];
				cls_pkg::CFG_MARGIN:  margin_q  <= cfg_data[CW-1:0];
				cls_pkg::CFG_CONFIRM: confirm_q <= cfg_data[cls_pkg::CONFIRM_W-1:0];
				cls_pkg::CFG_RELEASE: release_q <= cfg_data[cls_pkg::COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	assign enter_threshold          = enter_q;
	assign exit_threshold           = exit_q;
	assign hard_switch_threshold    = hard_q;
	assign switch_margin            = margin_q;
	assign confirm_time_ms          = confirm_q;
	assign uncertain_release_frames = release_q;

endmodule

@@ src/cls_update.sv @@
module cls_update #(
	parameter int CLASS_BITS = 6,
	parameter int CONF_BITS = 10
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  cls_pkg::upd_ctl_t             ctl,
	input  logic [CLASS_BITS-1:0]         class_index,
	input  logic                          is_sign_class,
	input  logic [CONF_BITS:0]            confidence,
	input  logic [cls_pkg::TIME_W-1:0]    time_ms,
	input  logic [CONF_BITS:0]            enter_threshold,
	input  logic [CONF_BITS:0]            exit_threshold,
	input  logic [CONF_BITS:0]            hard_switch_threshold,
	input  logic [CONF_BITS:0]            switch_margin,
	input  logic [cls_pkg::CONFIRM_W-1:0] confirm_time_ms,
	input  logic [cls_pkg::COUNT_W-1:0]   uncertain_release_frames,
	// state after this item, for the result register
	output logic                          stable_valid,
	output logic [CLASS_BITS-1:0]         stable_class,
	output logic [CONF_BITS:0]            stable_confidence,
	output logic                          live_valid,
	output logic [CLASS_BITS-1:0]         live_class
);

	localparam int CW = CONF_BITS + 1;
	localparam int TW = cls_pkg::TIME_W;
	localparam int NW = cls_pkg::COUNT_W;

	logic                  lv_q, cv_q, sv_q;
	logic [CLASS_BITS-1:0] lc_q, cc_q, sc_q;
	logic [CW-1:0]         lconf_q;
	logic [TW-1:0]         cs_q;
	logic [NW-1:0]         uc_q;

	logic                  lv_n, cv_n, sv_n;
	logic [CLASS_BITS-1:0] lc_n, cc_n, sc_n;
	logic [CW-1:0]         lconf_n;
	logic [TW-1:0]         cs_n;
	logic [NW-1:0]         uc_n;

	logic                  cand, switch_ok, rel, do_conf;
	logic [CW:0]           margin_sum;
	logic [TW-1:0]         elapsed;

	assign margin_sum = {1'b0, lconf_q} + {1'b0, switch_margin};

	always_comb begin
		lv_n    = lv_q;
		lc_n    = lc_q;
		lconf_n = lconf_q;
		cv_n    = cv_q;
		cc_n    = cc_q;
		cs_n    = cs_q;
		uc_n    = uc_q;
		sv_n    = sv_q;
		sc_n    = sc_q;
		rel     = 1'b0;
		do_conf = 1'b0;
		elapsed = '0;

		cand      = is_sign_class && (confidence >= enter_threshold);
		switch_ok = (confidence >= hard_switch_threshold) ||
			({1'b0, confidence} >= margin_sum);

		if (ctl.clear) begin
			lv_n    = 1'b0;
			lc_n    = '0;
			lconf_n = '0;
			cv_n    = 1'b0;
			cc_n    = '0;
			cs_n    = '0;
			uc_n    = '0;
			sv_n    = 1'b0;
			sc_n    = '0;
		end else if (ctl.ready) begin
			if (lv_q && !is_sign_class) begin
				if (uc_q != cls_pkg::COUNT_MAX)
					uc_n = uc_q + NW'(1);
			end else begin
				uc_n = '0;
			end

			rel = lv_q && ((uc_n >= uncertain_release_frames) ||
				(confidence < exit_threshold));
			if (rel) begin
				lv_n    = 1'b0;
				lc_n    = '0;
				lconf_n = '0;
				cv_n    = 1'b0;
				cc_n    = '0;
				cs_n    = '0;
				uc_n    = '0;
			end

			if (!lv_n) begin
				if (cand)
					do_conf = 1'b1;
			end else if (is_sign_class && class_index == lc_q) begin
				lconf_n = confidence;
			end else if (cand && switch_ok) begin
				do_conf = 1'b1;
			end

			if (do_conf) begin
				if (!(cv_n && cc_n == class_index)) begin
					cv_n = 1'b1;
					cc_n = class_index;
					cs_n = time_ms;
				end
				// wrapping elapsed time since the candidate first showed up
				elapsed = time_ms - cs_n;
				if (elapsed >= TW'(confirm_time_ms)) begin
					lv_n    = 1'b1;
					lc_n    = cc_n;
					lconf_n = confidence;
					uc_n    = '0;
				end
			end else begin
				cv_n = 1'b0;
				cc_n = '0;
				cs_n = '0;
			end

			sv_n = is_sign_class && (confidence >= exit_threshold);
			sc_n = sv_n ? class_index : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lv_q    <= 1'b0;
			lc_q    <= '0;
			lconf_q <= '0;
			cv_q    <= 1'b0;
			cc_q    <= '0;
			cs_q    <= '0;
			uc_q    <= '0;
			sv_q    <= 1'b0;
			sc_q    <= '0;
		end else if (ctl.fire) begin
			lv_q    <= lv_n;
			lc_q    <= lc_n;
			lconf_q <= lconf_n;
			cv_q    <= cv_n;
			cc_q    <= cc_n;
			cs_q    <= cs_n;
			uc_q    <= uc_n;
			sv_q    <= sv_n;
			sc_q    <= sc_n;
		end
	end

	assign stable_valid      = lv_n;
	assign stable_class      = lv_n ? lc_n : '0;
	assign stable_confidence = lv_n ? lconf_n : '0;
	assign live_valid        = sv_n;
	assign live_class        = sv_n ? sc_n : '0;

`ifndef SYNTHESIS
	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.fire && ctl.clear |=> !lv_q && !sv_q && !cv_q && uc_q == '0)
		else $error("clear item left state behind");

	a_idle_latch_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!lv_q |-> lc_q == '0 && lconf_q == '0)
		else $error("released latch holds class or confidence");

	a_count_needs_latch: assert property (@(posedge clk) disable iff (!arst_n)
		uc_q != '0 |-> lv_q)
		else $error("uncertain count running with no latched sign");

	a_hold_without_fire: assert property (@(posedge clk) disable iff (!arst_n)
		!ctl.fire |=> $stable(lv_q) && $stable(cs_q) && $stable(uc_q))
		else $error("state moved with no item");
`endif

endmodule
